// ----- rtl/pfx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the postfix expression evaluator.
// No dependencies; every other file of the block imports this package.

package pfx_pkg;

   // Default sizes, handed to the top-level parameters.
   localparam int STACK_DEPTH_DEF = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Entries in the command queue between front and back (a power of two).
   localparam int QUEUE_DEPTH = 4;

   // Operation codes carried from the front to the back.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 4'd1;
   localparam logic [OP_W-1:0] OP_SUB     = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL     = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV     = 4'd4;
   localparam logic [OP_W-1:0] OP_REM     = 4'd5;
   localparam logic [OP_W-1:0] OP_AND     = 4'd6;
   localparam logic [OP_W-1:0] OP_XOR     = 4'd7;
   localparam logic [OP_W-1:0] OP_OR      = 4'd8;
   localparam logic [OP_W-1:0] OP_DISCARD = 4'd9;

   // Status codes of a result beat.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO  = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   // ASCII characters the front recognises.
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   // Input beat: one character of the expression.
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_expr;
   } pfx_req_type;

   // Result beat: top of stack and sticky status.
   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } pfx_rsp_type;

   // Work for the back, in execution order: subtraction left over from a
   // held minus, push of a finished number, operator, emission of a result.
   typedef struct packed {
      logic            pre_sub;
      logic            push_num;
      logic [OP_W-1:0] op;
      logic            emit;
   } pfx_cmd_type;

   // Control of the iterative multiply and divide unit.
   typedef struct packed {
      logic start;
      logic is_mul;
      logic want_rem;
   } pfx_md_ctl_type;

endpackage

// ----- rtl/pfx_front.sv -----
`timescale 1ns / 1ps
// Front of the evaluator: accepts characters, builds numbers and classifies
// operators into commands for the back. Depends on pfx_pkg.

module pfx_front #(
   parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pfx_pkg::pfx_req_type     req_payload,
   input  logic                     q_full,
   output logic                     q_push,
   output pfx_pkg::pfx_cmd_type     q_cmd,
   output logic [VALUE_WIDTH-1:0]   q_num
);
   import pfx_pkg::*;

   logic                   accept;
   logic                   digit;
   logic                   last;
   logic [7:0]             ch;
   logic [VALUE_WIDTH-1:0] accum_ff, accum_in;
   logic                   in_number_ff, in_number_in;
   logic                   negative_ff, negative_in;
   logic                   pending_minus_ff, pending_minus_in;
   logic [VALUE_WIDTH-1:0] num_acc;
   logic                   num_neg;
   logic                   num_live;
   pfx_cmd_type            cmd;

   assign ch        = req_payload.ch;
   assign last      = req_payload.end_of_expr;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);

   // Classify the character against the number and minus state.
   always_comb begin
      cmd              = '0;
      cmd.op           = OP_NONE;
      num_acc          = accum_ff;
      num_neg          = negative_ff;
      num_live         = in_number_ff;
      pending_minus_in = 1'b0;

      // A held minus becomes a sign before a digit, otherwise a subtraction.
      if (pending_minus_ff) begin
         if (digit) begin
            num_live = 1'b1;
            num_neg  = 1'b1;
            num_acc  = '0;
         end else begin
            cmd.pre_sub = 1'b1;
         end
      end

      if (digit) begin
         if (!num_live) begin
            num_live = 1'b1;
            num_neg  = 1'b0;
            num_acc  = '0;
         end
         // Times ten as two shifted adds, wrapping at the value width.
         num_acc = (num_acc << 3) + (num_acc << 1) + VALUE_WIDTH'(ch[3:0]);
      end else begin
         cmd.push_num = num_live;
         num_live     = 1'b0;
         unique case (ch)
            CH_SPACE: begin
               cmd.op = OP_NONE;
            end
            CH_MINUS: begin
               if (last) begin
                  cmd.op = OP_SUB;
               end else begin
                  pending_minus_in = 1'b1;
               end
            end
            CH_PLUS:    cmd.op = OP_ADD;
            CH_STAR:    cmd.op = OP_MUL;
            CH_SLASH:   cmd.op = OP_DIV;
            CH_PERCENT: cmd.op = OP_REM;
            CH_AMP:     cmd.op = OP_AND;
            CH_CARET:   cmd.op = OP_XOR;
            CH_BAR:     cmd.op = OP_OR;
            default:    cmd.op = OP_DISCARD;
         endcase
      end

      // The end mark terminates any number and asks for a result.
      if (last) begin
         cmd.emit = 1'b1;
         if (digit) begin
            cmd.push_num = 1'b1;
         end
         num_live = 1'b0;
      end

      q_num = num_neg ? (VALUE_WIDTH'(0) - num_acc) : num_acc;

      in_number_in = num_live;
      accum_in     = num_live ? num_acc : '0;
      negative_in  = num_live ? num_neg : 1'b0;
   end

   // Only characters that leave work for the back enter the queue.
   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.pre_sub || cmd.push_num || (cmd.op != OP_NONE) || cmd.emit);

   // Number and minus state.
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff         <= '0;
         in_number_ff     <= 1'b0;
         negative_ff      <= 1'b0;
         pending_minus_ff <= 1'b0;
      end else if (accept) begin
         accum_ff         <= accum_in;
         in_number_ff     <= in_number_in;
         negative_ff      <= negative_in;
         pending_minus_ff <= pending_minus_in;
      end
   end

endmodule

// ----- rtl/pfx_queue.sv -----
`timescale 1ns / 1ps
// Short command queue that decouples the front from the back.
// Depends on pfx_pkg for the command type and the queue depth.

module pfx_queue #(
   parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pfx_pkg::pfx_cmd_type   push_cmd,
   input  logic [VALUE_WIDTH-1:0] push_num,
   output logic                   full,
   input  logic                   pop,
   output logic                   out_valid,
   output pfx_pkg::pfx_cmd_type   out_cmd,
   output logic [VALUE_WIDTH-1:0] out_num
);
   import pfx_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   pfx_cmd_type            cmd_mem [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0] num_mem [QUEUE_DEPTH];
   logic [PtrW-1:0]        wr_ptr_ff;
   logic [PtrW-1:0]        rd_ptr_ff;
   logic [CntW-1:0]        count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = cmd_mem[rd_ptr_ff];
   assign out_num   = num_mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_mem[wr_ptr_ff] <= push_cmd;
         num_mem[wr_ptr_ff] <= push_num;
      end
   end

   // Pointers and fill count; the depth is a power of two so they wrap.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

// ----- rtl/pfx_muldiv.sv -----
`timescale 1ns / 1ps
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// Depends on pfx_pkg for its control struct.

module pfx_muldiv #(
   parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pfx_pkg::pfx_md_ctl_type  ctl,
   input  logic [VALUE_WIDTH-1:0]   a,
   input  logic [VALUE_WIDTH-1:0]   b,
   output logic                     done,
   output logic [VALUE_WIDTH-1:0]   result
);
   import pfx_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(W);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic          is_mul_ff;
   logic          want_rem_ff;
   logic          neg_q_ff;
   logic          neg_r_ff;
   logic [W-1:0]  acc_ff;
   logic [W-1:0]  shf_ff;
   logic [W-1:0]  opd_ff;
   logic [W-1:0]  mag_a;
   logic [W-1:0]  mag_b;
   logic [W:0]    trial_rem;
   logic [W:0]    trial_diff;
   logic          fits;

   // Magnitudes for the divider; the most negative value fits unsigned.
   assign mag_a = a[W-1] ? (W'(0) - a) : a;
   assign mag_b = b[W-1] ? (W'(0) - b) : b;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign trial_rem  = {acc_ff, shf_ff[W-1]};
   assign trial_diff = trial_rem - {1'b0, opd_ff};
   assign fits       = !trial_diff[W];

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: acc holds product or remainder, shf the multiplier or quotient.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         is_mul_ff   <= ctl.is_mul;
         want_rem_ff <= ctl.want_rem;
         neg_q_ff    <= a[W-1] ^ b[W-1];
         neg_r_ff    <= a[W-1];
         acc_ff      <= '0;
         if (ctl.is_mul) begin
            shf_ff <= b;
            opd_ff <= a;
         end else begin
            shf_ff <= mag_a;
            opd_ff <= mag_b;
         end
      end else if (busy_ff) begin
         if (is_mul_ff) begin
            if (shf_ff[0]) begin
               acc_ff <= acc_ff + opd_ff;
            end
            opd_ff <= opd_ff << 1;
            shf_ff <= shf_ff >> 1;
         end else begin
            acc_ff <= fits ? trial_diff[W-1:0] : trial_rem[W-1:0];
            shf_ff <= {shf_ff[W-2:0], fits};
         end
      end
   end

   // Signs are restored on the way out: quotient toward zero, remainder
   // with the sign of the dividend.
   always_comb begin
      if (is_mul_ff) begin
         result = acc_ff;
      end else if (want_rem_ff) begin
         result = neg_r_ff ? (W'(0) - acc_ff) : acc_ff;
      end else begin
         result = neg_q_ff ? (W'(0) - shf_ff) : shf_ff;
      end
   end

   assign done = done_ff;

endmodule

// ----- rtl/pfx_back.sv -----
`timescale 1ns / 1ps
// Back of the evaluator: runs queued commands on the operand stack and
// drives the result register. Depends on pfx_pkg and pfx_muldiv.

module pfx_back #(
   parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  pfx_pkg::pfx_cmd_type   q_cmd,
   input  logic [VALUE_WIDTH-1:0] q_num,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pfx_pkg::pfx_rsp_type   rsp_payload
);
   import pfx_pkg::*;

   localparam int W    = VALUE_WIDTH;
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int SPW  = $clog2(STACK_DEPTH + 1);
   localparam int ExtW = (W > 32) ? W : 32;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_NEXT = 3'd1;
   localparam logic [2:0] S_OPRD = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]      state_ff, state_in;
   pfx_cmd_type     cmd_ff, cmd_in;
   logic [W-1:0]    num_ff, num_in;
   logic [OP_W-1:0] exec_op_ff, exec_op_in;
   logic [SPW-1:0]  sp_ff, sp_in;
   logic [1:0]      err_ff, err_in;
   logic [W-1:0]    stack_mem [STACK_DEPTH];
   logic [W-1:0]    rd_a_ff;
   logic [W-1:0]    rd_b_ff;
   logic            rsp_valid_ff;
   pfx_rsp_type     rsp_payload_ff, rsp_payload_in;
   logic            rsp_load;

   logic [SPW-1:0]  sp_m1;
   logic [SPW-1:0]  sp_m2;
   logic [AW-1:0]   addr_top;
   logic [AW-1:0]   addr_next;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [W-1:0]    wr_data;
   logic            do_op;
   logic [OP_W-1:0] opc;
   logic            write_result;
   logic [W-1:0]    op_result;
   logic [ExtW-1:0] top_ext;

   pfx_md_ctl_type  md_ctl;
   logic            md_done;
   logic [W-1:0]    md_result;

   function automatic logic [1:0] sticky(input logic [1:0] cur, input logic [1:0] code);
      return (cur == ST_OK) ? code : cur;
   endfunction

   assign sp_m1     = sp_ff - SPW'(1);
   assign sp_m2     = sp_ff - SPW'(2);
   assign addr_top  = sp_m1[AW-1:0];
   assign addr_next = sp_m2[AW-1:0];
   assign top_ext   = ExtW'($signed(rd_b_ff));

   pfx_muldiv #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (md_ctl),
      .a      (rd_a_ff),
      .b      (rd_b_ff),
      .done   (md_done),
      .result (md_result)
   );

   // Sequencer over the actions of one command.
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      num_in         = num_ff;
      exec_op_in     = exec_op_ff;
      sp_in          = sp_ff;
      err_in         = err_ff;
      wr_en          = 1'b0;
      wr_addr        = addr_next;
      wr_data        = '0;
      q_pop          = 1'b0;
      rsp_load       = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      md_ctl         = '0;
      md_ctl.is_mul  = (exec_op_ff == OP_MUL);
      md_ctl.want_rem = (exec_op_ff == OP_REM);
      do_op          = 1'b0;
      opc            = OP_NONE;
      write_result   = 1'b0;
      op_result      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               num_in   = q_num;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (cmd_ff.pre_sub) begin
               cmd_in.pre_sub = 1'b0;
               do_op          = 1'b1;
               opc            = OP_SUB;
            end else if (cmd_ff.push_num) begin
               cmd_in.push_num = 1'b0;
               // A push onto a full stack is dropped and flagged.
               if (sp_ff == SPW'(STACK_DEPTH)) begin
                  err_in = sticky(err_ff, ST_OVERFLOW);
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = sp_ff[AW-1:0];
                  wr_data = num_ff;
                  sp_in   = sp_ff + SPW'(1);
               end
            end else if (cmd_ff.op != OP_NONE) begin
               cmd_in.op = OP_NONE;
               do_op     = 1'b1;
               opc       = cmd_ff.op;
            end else if (cmd_ff.emit) begin
               cmd_in.emit = 1'b0;
               state_in    = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end

            // Fewer than two operands empties the stack; an operator pushes 0.
            if (do_op) begin
               if (sp_ff < SPW'(2)) begin
                  err_in = sticky(err_ff, ST_UNDERFLOW);
                  if (opc == OP_DISCARD) begin
                     sp_in = '0;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = '0;
                     sp_in   = SPW'(1);
                  end
               end else begin
                  exec_op_in = opc;
                  state_in   = S_OPRD;
               end
            end
         end
         S_OPRD: begin
            // Both operands are in the read registers now.
            state_in = S_NEXT;
            unique case (exec_op_ff) inside
               OP_DISCARD: begin
                  sp_in = sp_m2;
               end
               OP_ADD: begin
                  write_result = 1'b1;
                  op_result    = rd_a_ff + rd_b_ff;
               end
               OP_SUB: begin
                  write_result = 1'b1;
                  op_result    = rd_a_ff - rd_b_ff;
               end
               OP_AND: begin
                  write_result = 1'b1;
                  op_result    = rd_a_ff & rd_b_ff;
               end
               OP_XOR: begin
                  write_result = 1'b1;
                  op_result    = rd_a_ff ^ rd_b_ff;
               end
               OP_OR: begin
                  write_result = 1'b1;
                  op_result    = rd_a_ff | rd_b_ff;
               end
               OP_MUL: begin
                  md_ctl.start = 1'b1;
                  state_in     = S_WAIT;
               end
               OP_DIV, OP_REM: begin
                  if (rd_b_ff == '0) begin
                     err_in       = sticky(err_ff, ST_DIV_ZERO);
                     write_result = 1'b1;
                     op_result    = '0;
                  end else begin
                     md_ctl.start = 1'b1;
                     state_in     = S_WAIT;
                  end
               end
               default: begin
                  write_result = 1'b1;
                  op_result    = '0;
               end
            endcase
         end
         S_WAIT: begin
            if (md_done) begin
               write_result = 1'b1;
               op_result    = md_result;
               state_in     = S_NEXT;
            end
         end
         S_EMIT: begin
            // Load the result register once it is free or being taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               if (sp_ff == '0) begin
                  rsp_payload_in.value  = '0;
                  rsp_payload_in.status = sticky(err_ff, ST_UNDERFLOW);
               end else begin
                  rsp_payload_in.value  = top_ext[31:0];
                  rsp_payload_in.status = err_ff;
               end
               sp_in    = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Two operands popped, one result pushed in place of the lower.
      if (write_result) begin
         wr_en   = 1'b1;
         wr_addr = addr_next;
         wr_data = op_result;
         sp_in   = sp_m1;
      end
   end

   // Operand stack: one write port, two registered read ports at the top.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_b_ff <= stack_mem[addr_top];
      rd_a_ff <= stack_mem[addr_next];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmd_ff     <= '0;
         exec_op_ff <= OP_NONE;
         sp_ff      <= '0;
         err_ff     <= ST_OK;
      end else begin
         state_ff   <= state_in;
         cmd_ff     <= cmd_in;
         exec_op_ff <= exec_op_in;
         sp_ff      <= sp_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
   end

   // Result register; holds its beat while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The stack pointer never passes the stack depth.
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   // Emitting a result clears the expression state and presents the beat.
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (sp_ff == '0) && (err_ff == ST_OK) && rsp_valid_ff)
      else $error("expression state not cleared after emit");

   // The multiply and divide unit only starts with two operands on the stack.
   a_md_start: assert property (@(posedge clock) disable iff (reset)
      md_ctl.start |-> (state_ff == S_OPRD) && (sp_ff >= SPW'(2)))
      else $error("arithmetic unit started without two operands");

   // A finished multiply or divide is only reported while it is awaited.
   a_md_done: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == S_WAIT))
      else $error("arithmetic unit finished outside wait state");

endmodule

// ----- rtl/postfix_expression_evaluator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the postfix expression evaluator.
// Depends on pfx_pkg, pfx_front, pfx_queue and pfx_back.
// Usage:
//   The req channel takes one ASCII character per beat; end_of_expr marks the
//   last character of an expression. Numbers are decimal digit runs, a '-'
//   directly before a digit makes the number negative, tokens are separated
//   by spaces. For each end mark the rsp channel delivers one beat with the
//   top of the stack and a sticky status (ok, underflow, divide by zero,
//   overflow); the stack and status are then cleared for the next expression.
//   Timing: characters are taken one per cycle while the queue has room.
//   Digits make no command unless they carry the end mark, nor do spaces and
//   minus signs that close no number, follow no held minus and carry no end
//   mark; the rest enter a four-entry command queue. The back runs the actions
//   of each command in order; multiply, divide and remainder run one bit a
//   cycle in a shared iterative unit. A lone end mark passes through the queue
//   and the back's idle, next and emit states before its result is presented;
//   req_stall rises when the queue is full.
//   Reset clears the number, queue, stack pointer and status state; the stack
//   memory needs no clearing. While rsp_stall is high the beat is held.

module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_WIDTH = pfx_pkg::VALUE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pfx_pkg::pfx_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pfx_pkg::pfx_rsp_type rsp_payload
);
   import pfx_pkg::*;

   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   pfx_cmd_type            q_in_cmd;
   pfx_cmd_type            q_out_cmd;
   logic [VALUE_WIDTH-1:0] q_in_num;
   logic [VALUE_WIDTH-1:0] q_out_num;

   // Character intake and classification.
   pfx_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_in_cmd),
      .q_num       (q_in_num)
   );

   // Command queue between the two halves.
   pfx_queue #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .push_num  (q_in_num),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_cmd   (q_out_cmd),
      .out_num   (q_out_num)
   );

   // Stack execution and result delivery.
   pfx_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_cmd       (q_out_cmd),
      .q_num       (q_out_num),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/postfix_expression_evaluator_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for postfix_expression_evaluator_unit.
// Depends on pfx_pkg and the block's RTL; feeds character beats, predicts every
// result beat from the same characters and checks what the block delivers.

module postfix_expression_evaluator_unit_test;
   import pfx_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_OFF_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pfx_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pfx_rsp_type rsp_payload;

   // Predicted evaluator state, starting from its reset values.
   logic [31:0] calc_stack [DEPTH];
   int unsigned calc_depth = 0;
   logic [31:0] calc_accum = '0;
   bit          calc_in_number = 1'b0;
   bit          calc_negative = 1'b0;
   bit          calc_minus_held = 1'b0;
   logic [1:0]  calc_status = ST_OK;

   pfx_rsp_type expected_results [$];
   pfx_req_type pending_chars [$];
   int          error_count = 0;
   int          cycle_count = 0;

   // Idling state of both sides.
   int send_gap = 0;
   int send_mode_left = 0;
   bit send_quiet = 1'b0;
   int recv_gap = 0;
   int recv_mode_left = 0;
   bit recv_quiet = 1'b0;
   int hold_off_left = 0;
   int hold_off_wanted = 0;
   int hold_off_served = 0;

   postfix_expression_evaluator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The first error of an expression is the one that is reported.
   function automatic void note_status(logic [1:0] code);
      if (calc_status == ST_OK) calc_status = code;
   endfunction

   function automatic void push_operand(logic [31:0] operand);
      if (calc_depth >= DEPTH) begin
         note_status(ST_OVERFLOW);
      end else begin
         calc_stack[calc_depth] = operand;
         calc_depth++;
      end
   endfunction

   function automatic void close_number();
      push_operand(calc_negative ? 32'd0 - calc_accum : calc_accum);
      calc_in_number = 1'b0;
      calc_negative = 1'b0;
      calc_accum = '0;
   endfunction

   function automatic logic [OP_W-1:0] op_of_char(logic [7:0] c);
      case (c)
         CH_PLUS: return OP_ADD;
         CH_MINUS: return OP_SUB;
         CH_STAR: return OP_MUL;
         CH_SLASH: return OP_DIV;
         CH_PERCENT: return OP_REM;
         CH_AMP: return OP_AND;
         CH_CARET: return OP_XOR;
         CH_BAR: return OP_OR;
         default: return OP_DISCARD;
      endcase
   endfunction

   // Pops two operands and pushes the result; a short stack leaves a single 0.
   function automatic void apply_operator(logic [OP_W-1:0] op);
      logic signed [31:0] lhs;
      logic signed [31:0] rhs;
      logic [31:0]        mag_l;
      logic [31:0]        mag_r;
      logic [31:0]        res;
      if (calc_depth < 2) begin
         note_status(ST_UNDERFLOW);
         calc_depth = 0;
         push_operand('0);
         return;
      end
      rhs = calc_stack[calc_depth - 1];
      lhs = calc_stack[calc_depth - 2];
      calc_depth -= 2;
      mag_l = lhs[31] ? 32'd0 - lhs : lhs;
      mag_r = rhs[31] ? 32'd0 - rhs : rhs;
      res = '0;
      case (op) inside
         OP_ADD: res = lhs + rhs;
         OP_SUB: res = lhs - rhs;
         OP_MUL: res = lhs * rhs;
         OP_AND: res = lhs & rhs;
         OP_XOR: res = lhs ^ rhs;
         OP_OR: res = lhs | rhs;
         OP_DIV, OP_REM: begin
            // Both truncate toward zero; the remainder takes the dividend's sign.
            if (mag_r == 0) begin
               note_status(ST_DIV_ZERO);
            end else if (op == OP_DIV) begin
               res = mag_l / mag_r;
               if (lhs[31] != rhs[31]) res = 32'd0 - res;
            end else begin
               res = mag_l % mag_r;
               if (lhs[31]) res = 32'd0 - res;
            end
         end
         default: res = '0;
      endcase
      push_operand(res);
   endfunction

   function automatic void drop_pair();
      if (calc_depth < 2) begin
         note_status(ST_UNDERFLOW);
         calc_depth = 0;
      end else begin
         calc_depth -= 2;
      end
   endfunction

   // Advances the predicted state by one accepted beat and records any result.
   function automatic void evaluate_char(pfx_req_type beat);
      bit              is_digit;
      logic [OP_W-1:0] op;
      pfx_rsp_type     res;
      is_digit = beat.ch >= CH_ZERO && beat.ch <= CH_NINE;

      // A held minus becomes a sign before a digit and a subtraction otherwise.
      if (calc_minus_held) begin
         calc_minus_held = 1'b0;
         if (is_digit) begin
            calc_in_number = 1'b1;
            calc_negative = 1'b1;
            calc_accum = '0;
         end else begin
            apply_operator(OP_SUB);
         end
      end

      if (is_digit) begin
         if (!calc_in_number) begin
            calc_in_number = 1'b1;
            calc_negative = 1'b0;
            calc_accum = '0;
         end
         calc_accum = calc_accum * 32'd10 + 32'(beat.ch - CH_ZERO);
      end else begin
         if (calc_in_number) close_number();
         if (beat.ch == CH_MINUS) begin
            calc_minus_held = 1'b1;
         end else if (beat.ch != CH_SPACE) begin
            op = op_of_char(beat.ch);
            if (op == OP_DISCARD) drop_pair();
            else apply_operator(op);
         end
      end

      if (!beat.end_of_expr) return;

      // End of expression: settle what is open, emit the top, start afresh.
      if (calc_in_number) close_number();
      if (calc_minus_held) begin
         calc_minus_held = 1'b0;
         apply_operator(OP_SUB);
      end
      if (calc_depth == 0) begin
         note_status(ST_UNDERFLOW);
         res.value = '0;
      end else begin
         res.value = calc_stack[calc_depth - 1];
      end
      res.status = calc_status;
      expected_results.push_back(res);
      calc_depth = 0;
      calc_accum = '0;
      calc_in_number = 1'b0;
      calc_negative = 1'b0;
      calc_status = ST_OK;
   endfunction

   function automatic void queue_char(logic [7:0] c, bit last);
      pfx_req_type beat;
      beat.ch = c;
      beat.end_of_expr = last;
      pending_chars.push_back(beat);
   endfunction

   function automatic void queue_text(string text);
      for (int i = 0; i < text.len(); i++) queue_char(text[i], 1'b0);
   endfunction

   // Marks the most recently queued character as the end of its expression.
   function automatic void close_expression();
      pfx_req_type last;
      last = pending_chars.pop_back();
      last.end_of_expr = 1'b1;
      pending_chars.push_back(last);
   endfunction

   // Decimal operand text, leaning towards the extremes and small values.
   function automatic string operand_text();
      int              pick;
      longint unsigned mag;
      string           sign;
      pick = $urandom_range(0, 99);
      sign = "";
      if ($urandom_range(0, 2) == 0) sign = "-";
      if (pick < 5) return "2147483647";
      if (pick < 10) return "-2147483648";
      if (pick < 13) return "4294967296";
      if (pick < 16) return "99999999999";
      if (pick < 55) mag = $urandom_range(0, 20);
      else if (pick < 85) mag = $urandom_range(0, 99999);
      else mag = $urandom();
      return {sign, $sformatf("%0d", mag)};
   endfunction

   // Queues one random expression: mostly well formed, some broken, some noise.
   function automatic void add_expression();
      int    kind;
      int    operands;
      int    pushed;
      int    depth;
      int    tokens;
      int    pick;
      string ops;
      string text;
      ops = "+-*/&^|%";
      kind = $urandom_range(0, 99);
      text = "";
      if (kind < 5) begin
         // Most negative value over minus one, as a quotient or a remainder.
         pick = 3 + 4 * $urandom_range(0, 1);
         queue_text({"-2147483648 -1 ", ops.substr(pick, pick)});
         close_expression();
      end else if (kind < 70) begin
         // Deep expressions push every operand first and may overflow the stack.
         operands = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19)
                                                : $urandom_range(1, 6);
         pushed = 0;
         depth = 0;
         while (pushed < operands || depth > 1) begin
            if (pushed < operands && (depth < 2 || operands > 12 || $urandom_range(0, 1))) begin
               if (text.len() != 0) begin
                  if ($urandom_range(0, 9) == 0) text = {text, "  "};
                  else text = {text, " "};
               end
               text = {text, operand_text()};
               pushed++;
               depth++;
            end else begin
               if ($urandom_range(0, 9) < 7) text = {text, " "};
               pick = $urandom_range(0, 7);
               text = {text, ops.substr(pick, pick)};
               depth--;
            end
         end
         if ($urandom_range(0, 4) == 0) text = {text, " "};
         queue_text(text);
         close_expression();
      end else if (kind < 88) begin
         tokens = $urandom_range(1, 8);
         for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 3))
               0: queue_text(operand_text());
               1: queue_char(ops[$urandom_range(0, 7)], 1'b0);
               2: queue_char(8'($urandom_range(0, 255)), 1'b0);
               default: queue_char(CH_SPACE, 1'b0);
            endcase
         end
         close_expression();
      end else begin
         tokens = $urandom_range(1, 12);
         for (int t = 0; t < tokens; t++)
            queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 1)) close_expression();
      end
   endfunction

   // Mostly no gap, some short ones and a few long ones.
   function automatic int gap_length(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic await_idle();
      while (pending_chars.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Character driver: predicts each accepted beat, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && !req_stall) evaluate_char(req_payload);
         if (send_mode_left == 0) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            send_mode_left = 200;
         end else begin
            send_mode_left--;
         end
         if (req_valid && req_stall) begin
            // The beat is held until the block takes it.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            req_payload <= pending_chars.pop_front();
            req_valid <= 1'b1;
            send_gap = gap_length(send_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (recv_mode_left == 0) begin
            recv_quiet = ($urandom_range(0, 3) == 0);
            recv_mode_left = 150;
         end else begin
            recv_mode_left--;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else if (hold_off_served != hold_off_wanted) begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            recv_gap = gap_length(recv_quiet);
         end
      end
   end

   // Result checker: each accepted beat against the oldest prediction.
   always @(posedge clock) begin
      pfx_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result beat: value %0d status %0d",
                   rsp_payload.value, rsp_payload.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_payload.value);
               error_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               error_count++;
            end
         end
      end
   end

   // Stimulus phases and the final verdict.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every operator with a trailing minus as subtraction.
      queue_text("8 3%5^2|6&9*4+7/1-");
      close_expression();
      // Negative number, divide by zero, then a sticky status over an underflow.
      queue_text("-1 0%+");
      close_expression();
      // Unknown characters at both ends of the byte range, a number ended by the end mark.
      queue_char(8'h00, 1'b0);
      queue_text(" 7");
      close_expression();
      queue_char(8'hFF, 1'b1);
      await_idle();

      // Random traffic with a long receiver hold-off so that the input backs up.
      hold_off_wanted++;
      while (pending_chars.size() < 650) add_expression();
      await_idle();

      while (pending_chars.size() < 850) add_expression();
      await_idle();
      repeat (200) @(posedge clock);

      if (error_count == 0) begin
         $display("postfix_expression_evaluator_unit_test: clean");
      end else begin
         $display("postfix_expression_evaluator_unit_test: errors");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("postfix_expression_evaluator_unit_test: errors");
      $finish;
   end

endmodule
